### hdl/nearest_rank_percentile_defines.svh
// Assertion macros for the nearest-rank percentile block
`ifndef NEAREST_RANK_PERCENTILE_DEFINES_SVH
`define NEAREST_RANK_PERCENTILE_DEFINES_SVH

`ifndef SYNTHESIS

`define NRP_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define NRP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define NRP_ASSERT_SAME(lbl, ante, cons, msg)

`define NRP_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

### hdl/nrp_pkg.sv
package nrp_pkg;

    localparam logic [6:0]  PCT_FULL = 7'd100;
    localparam logic [31:0] KEY_BIAS = 32'h8000_0000;

    // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for x up to 100 * 4096 + 99
    localparam int                 RECIP_W     = 19;
    localparam logic [RECIP_W-1:0] RECIP_100   = 19'd335545;
    localparam int                 RECIP_SHIFT = 25;

    typedef struct packed {
        logic clear;
        logic acc;
    } cnt_ctl_t;

endpackage

### hdl/nrp_sample_ram.sv
module nrp_sample_ram #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          clk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [31:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [31:0]   rd_data
);

    logic [31:0] mem [DEPTH];
    logic [31:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### hdl/nrp_rank_div.sv
module nrp_rank_div #(
    parameter int XW = 15
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [XW-1:0] dividend,
    output logic          done,
    output logic [XW-1:0] quotient
);
    import nrp_pkg::*;

    localparam int PW = XW + RECIP_W;

    logic [XW-1:0] acc_reg;
    logic [XW-1:0] quot_reg;
    logic          busy_reg;
    logic          done_reg;
    logic [PW-1:0] prod;

    assign prod = PW'(acc_reg) * PW'(RECIP_100);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= dividend;
        end
        else if (busy_reg)
        begin
            quot_reg <= XW'(prod >> RECIP_SHIFT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= start;
            done_reg <= busy_reg;
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

### hdl/nrp_match_count.sv
module nrp_match_count #(
    parameter int CW = 9
) (
    input  logic            clk,
    input  logic            rst_n,
    input  nrp_pkg::cnt_ctl_t ctl,
    input  logic [31:0]     data,
    input  logic [31:0]     prefix,
    input  logic [31:0]     mask,
    output logic [CW-1:0]   count
);
    import nrp_pkg::*;

    logic [CW-1:0] count_reg;
    logic          hit;

    assign hit = (((data ^ KEY_BIAS ^ prefix) & mask) == 32'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (ctl.clear)
        begin
            count_reg <= '0;
        end
        else if (ctl.acc && hit)
        begin
            count_reg <= count_reg + 1'b1;
        end
    end

    assign count = count_reg;

endmodule

### hdl/nearest_rank_percentile.sv
// Nearest-rank percentile selection.
// Input channel (in_valid/in_ready) carries one request per sample: a signed
// 32-bit sample and a last flag. Samples load at one per cycle while in_ready
// is high into an internal store of MAX_SAMPLES entries; samples past a full
// store are dropped and flagged. The request marked last closes the set of N
// samples and starts the selection: the rank product, the reciprocal divide by
// 100, then a radix search over the 32 key bits, each pass a scan of the N
// samples through one compare and count unit reading the store's single read
// port plus a decide step, and last the load of the output register. in_ready
// is low from the last request until the result is loaded into that register.
// Output channel (out_valid/out_ready) gives selected and overflow from an output
// register; the next set may load while a result waits, and a further selection
// holds in its final step until the register is free.
// The percentile register (cfg_we/cfg_wdata, reset 50) is to be written only
// when idle; the block does not enforce this. Reset clears the sample count,
// drop flag and output valid; store contents are left as they are.
`include "nearest_rank_percentile_defines.svh"

module nearest_rank_percentile #(
    parameter int MAX_SAMPLES = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [31:0] sample,
    input  logic               last,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] selected,
    output logic               overflow,
    input  logic               cfg_we,
    input  logic [6:0]         cfg_wdata
);
    import nrp_pkg::*;

    localparam int CW = $clog2(MAX_SAMPLES + 1);
    localparam int AW = $clog2(MAX_SAMPLES);
    localparam int XW = $clog2(100 * MAX_SAMPLES + 100);

    localparam logic [2:0] ST_LOAD   = 3'd0;
    localparam logic [2:0] ST_MUL    = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_SCAN   = 3'd3;
    localparam logic [2:0] ST_DECIDE = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0]    state_reg;
    logic [6:0]    pct_reg;
    logic [CW-1:0] count_reg;
    logic          dropped_reg;
    logic [CW-1:0] n_reg;
    logic          drop_set_reg;
    logic [CW-1:0] rank_reg;
    logic [CW-1:0] idx_reg;
    logic [4:0]    bit_reg;
    logic [31:0]   prefix_reg;
    logic          rd_pend_reg;
    logic          out_valid_reg;
    logic [31:0]   selected_reg;
    logic          overflow_reg;

    logic          in_fire;
    logic          full;
    logic [6:0]    p_sat;
    logic [XW-1:0] dividend;
    logic          div_done;
    logic [XW-1:0] quotient;
    logic [CW-1:0] q_rank;
    logic          rd_en;
    logic [31:0]   rd_data;
    logic [31:0]   mask;
    logic [CW-1:0] match_cnt;
    cnt_ctl_t      cnt_ctl;
    logic          out_free;

    assign in_ready = (state_reg == ST_LOAD);
    assign in_fire  = in_valid && in_ready;
    assign full     = (count_reg == CW'(MAX_SAMPLES));
    assign out_free = !out_valid_reg || out_ready;

    assign p_sat    = (pct_reg > PCT_FULL) ? PCT_FULL : pct_reg;
    assign dividend = XW'(p_sat) * XW'(n_reg) + XW'(PCT_FULL - 7'd1);
    assign q_rank   = (quotient == '0) ? '0 : CW'(quotient - 1'b1);

    assign rd_en   = (state_reg == ST_SCAN) && (idx_reg < n_reg);
    assign mask    = ~32'd0 << bit_reg;
    assign cnt_ctl = '{clear: (state_reg == ST_DIV) || (state_reg == ST_DECIDE),
                       acc:   rd_pend_reg};

    nrp_sample_ram #(
        .DEPTH (MAX_SAMPLES),
        .AW    (AW)
    ) u_ram (
        .clk     (clk),
        .wr_en   (in_fire && !full),
        .wr_addr (count_reg[AW-1:0]),
        .wr_data (sample),
        .rd_en   (rd_en),
        .rd_addr (idx_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    nrp_rank_div #(
        .XW (XW)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_MUL),
        .dividend (dividend),
        .done     (div_done),
        .quotient (quotient)
    );

    nrp_match_count #(
        .CW (CW)
    ) u_count (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (cnt_ctl),
        .data   (rd_data),
        .prefix (prefix_reg),
        .mask   (mask),
        .count  (match_cnt)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pct_reg <= 7'd50;
        end
        else if (cfg_we)
        begin
            pct_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            count_reg     <= '0;
            dropped_reg   <= 1'b0;
            rd_pend_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg <= rd_en;
            if ((state_reg == ST_DONE) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_LOAD:
                begin
                    if (in_fire)
                    begin
                        if (!full)
                        begin
                            count_reg <= count_reg + 1'b1;
                        end
                        else
                        begin
                            dropped_reg <= 1'b1;
                        end
                        if (last)
                        begin
                            state_reg <= ST_MUL;
                        end
                    end
                end
                ST_MUL:
                begin
                    state_reg <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if ((idx_reg == n_reg) && !rd_pend_reg)
                    begin
                        state_reg <= ST_DECIDE;
                    end
                end
                ST_DECIDE:
                begin
                    state_reg <= (bit_reg == 5'd0) ? ST_DONE : ST_SCAN;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        count_reg     <= '0;
                        dropped_reg   <= 1'b0;
                        state_reg     <= ST_LOAD;
                    end
                end
                default:
                begin
                    state_reg <= ST_LOAD;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_LOAD:
            begin
                if (in_fire && last)
                begin
                    n_reg        <= full ? count_reg : count_reg + 1'b1;
                    drop_set_reg <= dropped_reg || full;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    rank_reg   <= q_rank;
                    idx_reg    <= '0;
                    bit_reg    <= 5'd31;
                    prefix_reg <= '0;
                end
            end
            ST_SCAN:
            begin
                if (rd_en)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            ST_DECIDE:
            begin
                if (rank_reg >= match_cnt)
                begin
                    rank_reg            <= rank_reg - match_cnt;
                    prefix_reg[bit_reg] <= 1'b1;
                end
                bit_reg <= bit_reg - 1'b1;
                idx_reg <= '0;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    selected_reg <= prefix_reg ^ KEY_BIAS;
                    overflow_reg <= drop_set_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign selected  = selected_reg;
    assign overflow  = overflow_reg;

    `NRP_ASSERT_NEXT(a_last_starts, in_fire && last, state_reg == ST_MUL, "last request did not start selection")
    `NRP_ASSERT_SAME(a_rank_in_set, state_reg == ST_SCAN, rank_reg < n_reg, "rank outside the set")
    `NRP_ASSERT_SAME(a_count_bound, state_reg == ST_DECIDE, match_cnt <= n_reg, "match count exceeds set size")
    `NRP_ASSERT_NEXT(a_drop_flag, in_fire && !last && full, dropped_reg, "drop on full store not flagged")

endmodule
